FILE: rtl/core/piezo_trigger_note_generator_macros.svh
// assertion helpers for the note generator
`ifndef PIEZO_TRIGGER_NOTE_GENERATOR_MACROS_SVH
`define PIEZO_TRIGGER_NOTE_GENERATOR_MACROS_SVH

`ifndef ASSERT_OFF
`define PTNG_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define PTNG_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define PTNG_ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define PTNG_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`endif

`endif

FILE: rtl/core/ptng_pkg.sv
package ptng_pkg;

  typedef enum logic {
    EvNoteOn  = 1'b0,
    EvNoteOff = 1'b1
  } event_kind_t;

  // register indexes, decoded from paddr[3:2]
  localparam logic [1:0] RegTonic   = 2'd0;
  localparam logic [1:0] RegRetrig  = 2'd1;
  localparam logic [1:0] RegNoteLen = 2'd2;

  localparam logic [6:0]  TonicReset   = 7'd60;
  localparam logic [15:0] RetrigReset  = 16'd40;
  localparam logic [15:0] NoteLenReset = 16'd200;

  localparam logic [7:0] VelBase = 8'd40;
  localparam logic [7:0] VelMax  = 8'd127;

  // button offsets, bit 0 first, negative steps in two's complement
  localparam logic [7:0] BtnOffset [8] = '{
    8'd7, 8'd5, 8'd4, 8'd2, 8'hFF, 8'd12, 8'd24, 8'hF4
  };

  typedef struct packed {
    logic [6:0]  tonic_note;
    logic [15:0] retrigger_timeout_ms;
    logic [15:0] note_length_ms;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  buttons_pressed;
    logic [9:0]  fader_threshold;
    logic [9:0]  piezo_level;
    logic [31:0] time_ms;
  } sample_t;

  typedef struct packed {
    logic [31:0] last_strike_time;
    logic [7:0]  sounding_pitch;
    logic        note_sounding;
  } note_state_t;

  typedef struct packed {
    event_kind_t event_kind;
    logic [7:0]  note_pitch;
    logic [6:0]  note_velocity;
    logic        last_event;
  } evt_t;

  typedef struct packed {
    logic [1:0]  n_push;
    evt_t        ev0;
    evt_t        ev1;
    note_state_t state_next;
  } step_t;

endpackage

FILE: rtl/core/piezo_trigger_note_generator.sv
// an accepted sample waits in the input register, then its events go to the event queue,
// whose head drives the master side; throughput: one sample per cycle while events drain;
// the master side moves one event per cycle while ready, and a strike over a sounding note
// queues two events; a sample leaves the input register only when the queue has room for
// two events; reset: synchronous, active high; registers return to their defaults, no note
// sounds, input stage and event queue are emptied
`include "piezo_trigger_note_generator_macros.svh"

module piezo_trigger_note_generator
  import ptng_pkg::*;
#(
  parameter int Depth = 4
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] time_ms, [41:32] piezo_level, [51:42] fader_threshold,
  // [59:52] buttons_pressed, [63:60] zero
  input  logic [63:0] s_axis_tdata,

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] note_pitch, [14:8] note_velocity, [15] zero
  output logic [15:0] m_axis_tdata,
  // [0] event_kind
  output logic        m_axis_tuser,
  output logic        m_axis_tlast,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntRoom = CntW'(Depth - 2);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cfg_t        cfg;
  note_state_t state;
  step_t       step;

  logic        in_valid;
  sample_t     in_sample;
  logic        proc_fire;

  evt_t            fifo_mem [Depth];
  logic [PtrW-1:0] wptr;
  logic [PtrW-1:0] wptr_inc;
  logic [PtrW-1:0] wptr_next;
  logic [PtrW-1:0] rptr;
  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;
  logic            pop;
  evt_t            head;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tonic_note           <= TonicReset;
      cfg.retrigger_timeout_ms <= RetrigReset;
      cfg.note_length_ms       <= NoteLenReset;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        RegTonic:   cfg.tonic_note           <= pwdata[6:0];
        RegRetrig:  cfg.retrigger_timeout_ms <= pwdata[15:0];
        RegNoteLen: cfg.note_length_ms       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegTonic:   prdata = {25'd0, cfg.tonic_note};
      RegRetrig:  prdata = {16'd0, cfg.retrigger_timeout_ms};
      RegNoteLen: prdata = {16'd0, cfg.note_length_ms};
      default:    prdata = 32'd0;
    endcase
  end

  // input stage
  assign proc_fire     = in_valid && (count <= CntRoom);
  assign s_axis_tready = !in_valid || proc_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_sample <= s_axis_tdata[59:0];
    end
  end

  ptng_step u_step (
    .cfg    (cfg),
    .state  (state),
    .sample (in_sample),
    .step   (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (proc_fire) begin
      state <= step.state_next;
    end
  end

  // event queue
  assign wptr_inc = (wptr == PtrLast) ? '0 : wptr + 1'b1;

  always_comb begin
    wptr_next  = wptr;
    count_next = count;
    if (proc_fire) begin
      unique case (step.n_push)
        2'd1:    wptr_next = wptr_inc;
        2'd2:    wptr_next = (wptr_inc == PtrLast) ? '0 : wptr_inc + 1'b1;
        default: wptr_next = wptr;
      endcase
      count_next = count + {{(CntW-2){1'b0}}, step.n_push};
    end
    if (pop) count_next = count_next - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (proc_fire && (step.n_push != 2'd0)) begin
      fifo_mem[wptr] <= step.ev0;
    end
    if (proc_fire && (step.n_push == 2'd2)) begin
      fifo_mem[wptr_inc] <= step.ev1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr_next;
      count <= count_next;
      if (pop) rptr <= (rptr == PtrLast) ? '0 : rptr + 1'b1;
    end
  end

  assign head          = fifo_mem[rptr];
  assign m_axis_tvalid = (count != '0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = {1'b0, head.note_velocity, head.note_pitch};
  assign m_axis_tuser  = head.event_kind;
  assign m_axis_tlast  = head.last_event;

  // checks
  `PTNG_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CntFull, "event queue overflow")
  `PTNG_ASSERT_IMPLIES(a_pair_needs_note, clk, rst, proc_fire && (step.n_push == 2'd2), state.note_sounding, "note off issued with no sounding note")
  `PTNG_ASSERT_IMPLIES(a_on_is_last, clk, rst, m_axis_tvalid && (m_axis_tuser == EvNoteOn), m_axis_tlast, "note on not marked last")
  `PTNG_ASSERT_IMPLIES(a_off_zero_vel, clk, rst, m_axis_tvalid && (m_axis_tuser == EvNoteOff), m_axis_tdata[14:8] == 7'd0, "note off with velocity")

endmodule

FILE: rtl/core/ptng_step.sv
module ptng_step
  import ptng_pkg::*;
(
  input  cfg_t        cfg,
  input  note_state_t state,
  input  sample_t     sample,
  output step_t       step
);

  logic [31:0] strike_gate;
  logic [31:0] release_gate;
  logic        strike;
  logic        release_due;
  logic [7:0]  pitch;
  logic [7:0]  vel_sum;
  logic [6:0]  vel;
  evt_t        ev_on;
  evt_t        ev_off;

  assign strike_gate  = state.last_strike_time + {16'd0, cfg.retrigger_timeout_ms};
  assign release_gate = state.last_strike_time + {16'd0, cfg.note_length_ms};

  assign strike      = (sample.piezo_level > sample.fader_threshold) &&
                       (sample.time_ms > strike_gate);
  assign release_due = state.note_sounding && (sample.time_ms > release_gate);

  always_comb begin
    pitch = {1'b0, cfg.tonic_note};
    for (int i = 0; i < 8; i++) begin
      if (sample.buttons_pressed[i]) pitch = pitch + BtnOffset[i];
    end
  end

  assign vel_sum = VelBase + {3'd0, sample.piezo_level[9:5]};
  assign vel     = (vel_sum > VelMax) ? VelMax[6:0] : vel_sum[6:0];

  always_comb begin
    ev_on.event_kind     = EvNoteOn;
    ev_on.note_pitch     = pitch;
    ev_on.note_velocity  = vel;
    ev_on.last_event     = 1'b1;
    ev_off.event_kind    = EvNoteOff;
    ev_off.note_pitch    = state.sounding_pitch;
    ev_off.note_velocity = 7'd0;
    ev_off.last_event    = 1'b1;
  end

  always_comb begin
    step.n_push     = 2'd0;
    step.ev0        = ev_off;
    step.ev1        = ev_on;
    step.state_next = state;
    priority if (strike) begin
      step.state_next.last_strike_time = sample.time_ms;
      step.state_next.sounding_pitch   = pitch;
      step.state_next.note_sounding    = 1'b1;
      if (state.note_sounding) begin
        // old note released ahead of the new one
        step.n_push         = 2'd2;
        step.ev0.last_event = 1'b0;
      end else begin
        step.n_push = 2'd1;
        step.ev0    = ev_on;
      end
    end else if (release_due) begin
      step.n_push                   = 2'd1;
      step.state_next.note_sounding = 1'b0;
    end else begin
      // no event for this sample
      step.n_push = 2'd0;
    end
  end

endmodule

FILE: test/note_event_checker.sv
`timescale 1ns / 100ps

module note_event_checker
  import ptng_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // [31:0] time_ms, [41:32] piezo_level, [51:42] fader_threshold,
  // [59:52] buttons_pressed, [63:60] zero
  input  logic [63:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] note_pitch, [14:8] note_velocity, [15] zero
  input  logic [15:0] m_axis_tdata,
  // [0] event_kind
  input  logic        m_axis_tuser,
  input  logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          outstanding,
  output int          note_ons,
  output int          note_offs
);

  typedef struct packed {
    event_kind_t kind;
    logic [7:0]  pitch;
    logic [6:0]  vel;
    logic        last;
  } note_evt_t;

  localparam logic [6:0]  TonicDefault   = 7'd60;
  localparam logic [15:0] RetrigDefault  = 16'd40;
  localparam logic [15:0] NoteLenDefault = 16'd200;
  localparam logic [7:0]  VelFloor       = 8'd40;
  localparam logic [7:0]  VelCeiling     = 8'd127;
  localparam int ButtonStep [8] = '{7, 5, 4, 2, -1, 12, 24, -12};

  logic [6:0]  tonic;
  logic [15:0] retrig_ms;
  logic [15:0] hold_ms;
  logic [31:0] strike_time;
  logic [7:0]  held_pitch;
  logic        sounding;

  note_evt_t due_events [$];
  int errs;
  int ons;
  int offs;

  function automatic logic [7:0] chord_pitch(logic [6:0] base, logic [7:0] btn);
    logic [7:0] p;
    p = {1'b0, base};
    for (int i = 0; i < 8; i++) begin
      if (btn[i]) p = p + 8'(ButtonStep[i]);
    end
    return p;
  endfunction

  function automatic note_evt_t make_evt(event_kind_t kind, logic [7:0] pitch,
                                         logic [6:0] vel, logic last);
    note_evt_t e;
    e.kind  = kind;
    e.pitch = pitch;
    e.vel   = vel;
    e.last  = last;
    return e;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errs++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : predict
    logic [31:0] now;
    logic [31:0] strike_gate;
    logic [31:0] release_gate;
    logic [9:0]  lvl;
    logic [9:0]  th;
    logic [7:0]  vel8;
    note_evt_t   got;
    note_evt_t   want;
    if (rst) begin
      tonic       = TonicDefault;
      retrig_ms   = RetrigDefault;
      hold_ms     = NoteLenDefault;
      strike_time = '0;
      held_pitch  = '0;
      sounding    = 1'b0;
      due_events.delete();
      errs = 0;
      ons  = 0;
      offs = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          RegTonic:   tonic     = pwdata[6:0];
          RegRetrig:  retrig_ms = pwdata[15:0];
          RegNoteLen: hold_ms   = pwdata[15:0];
          default: ;
        endcase
      end

      // compare before predicting, a new request never yields an event on the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        got = make_evt(event_kind_t'(m_axis_tuser), m_axis_tdata[7:0],
                       m_axis_tdata[14:8], m_axis_tlast);
        if (got.kind == EvNoteOn) ons++;
        else offs++;
        if (due_events.size() == 0) begin
          errs++;
          $display("%0t: unexpected event, expected none, got kind %0d pitch %0d vel %0d last %0d",
                   $time, got.kind, got.pitch, got.vel, got.last);
        end else begin
          want = due_events.pop_front();
          check_field("event_kind", want.kind, got.kind);
          check_field("note_pitch", want.pitch, got.pitch);
          check_field("note_velocity", want.vel, got.vel);
          check_field("last_event", want.last, got.last);
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        now = s_axis_tdata[31:0];
        lvl = s_axis_tdata[41:32];
        th  = s_axis_tdata[51:42];
        strike_gate  = strike_time + {16'd0, retrig_ms};
        release_gate = strike_time + {16'd0, hold_ms};
        if (lvl > th && now > strike_gate) begin
          vel8 = VelFloor + 8'(lvl >> 5);
          if (vel8 > VelCeiling) vel8 = VelCeiling;
          // a sounding note is cut before the new one starts
          if (sounding) due_events.push_back(make_evt(EvNoteOff, held_pitch, 7'd0, 1'b0));
          held_pitch = chord_pitch(tonic, s_axis_tdata[59:52]);
          due_events.push_back(make_evt(EvNoteOn, held_pitch, vel8[6:0], 1'b1));
          strike_time = now;
          sounding    = 1'b1;
        end else if (sounding && now > release_gate) begin
          due_events.push_back(make_evt(EvNoteOff, held_pitch, 7'd0, 1'b1));
          sounding = 1'b0;
        end
      end
    end
    mismatches  <= errs;
    outstanding <= due_events.size();
    note_ons    <= ons;
    note_offs   <= offs;
  end

endmodule

FILE: test/piezo_trigger_note_generator_tb.sv
`timescale 1ns / 100ps

module piezo_trigger_note_generator_tb;
  import ptng_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int HoldCycles    = 400;
  localparam int PhaseItems    = 166;
  localparam int PhaseCount    = 8;
  localparam int MaxGap        = 8;
  localparam int SettleCycles  = 8;
  localparam logic [1:0] RegUnused = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int outstanding;
  int note_ons;
  int note_offs;

  logic [31:0] now_ms = '0;
  bit          no_idle = 1'b0;
  int          hold_asks = 0;
  int          hold_served = 0;
  int          items_sent = 0;
  int          settings_used = 0;

  always #10 clk = ~clk;

  piezo_trigger_note_generator DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  note_event_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .note_ons      (note_ons),
    .note_offs     (note_offs)
  );

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // upper bits carry junk, only the register width may take effect
  task automatic write_config(input logic [6:0] tn, input logic [15:0] rt, input logic [15:0] nl);
    write_reg(RegTonic, ($urandom() & ~32'h7F) | {25'd0, tn});
    write_reg(RegRetrig, ($urandom() & ~32'hFFFF) | {16'd0, rt});
    write_reg(RegNoteLen, ($urandom() & ~32'hFFFF) | {16'd0, nl});
    settings_used++;
  endtask

  task automatic send_sample(input logic [31:0] t, input logic [9:0] lvl, input logic [9:0] th,
                             input logic [7:0] btn, input int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, btn, th, lvl, t};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  // wait for every event, then for any request still in flight that makes none
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic random_sample(input int span, input bit zero_gap);
    logic [31:0] t;
    logic [9:0]  lvl;
    logic [9:0]  th;
    int pick;
    pick = $urandom_range(0, 99);
    th   = 10'($urandom_range(0, 1023));
    lvl  = 10'($urandom_range(0, 1023));
    if (pick < 4) begin
      now_ms = $urandom();
      t = now_ms;
    end else if (pick < 8) begin
      // stale timestamp, behind the running clock
      t = now_ms - $urandom_range(0, span);
    end else begin
      now_ms = now_ms + $urandom_range(0, span);
      t = now_ms;
      if (pick < 75 && th != 10'h3FF) lvl = 10'($urandom_range(int'(th) + 1, 1023));
    end
    send_sample(t, lvl, th, 8'($urandom_range(0, 255)),
                zero_gap ? 0 : $urandom_range(0, MaxGap));
  endtask

  always begin : receiver
    int stall;
    @(posedge clk);
    if (!rst) begin
      if (hold_asks != hold_served) begin
        hold_served++;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      stall = no_idle ? 0 : $urandom_range(0, MaxGap);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: watchdog, no transfer for %0d cycles", $time, WatchdogLimit);
    $display("piezo_trigger_note_generator_tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    logic [6:0]  tn;
    logic [15:0] rt;
    logic [15:0] nl;
    int span;
    bit burst;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: early sample, first strike, retrigger block, level equal to threshold
    send_sample(32'd10, 10'd1023, 10'd0, 8'h00, $urandom_range(0, MaxGap));
    send_sample(32'd41, 10'd1023, 10'd0, 8'h00, $urandom_range(0, MaxGap));
    send_sample(32'd60, 10'd1023, 10'd0, 8'h00, $urandom_range(0, MaxGap));
    send_sample(32'd82, 10'd500, 10'd500, 8'h00, $urandom_range(0, MaxGap));
    // strike over a sounding note, all buttons
    send_sample(32'd82, 10'd501, 10'd500, 8'hFF, $urandom_range(0, MaxGap));
    send_sample(32'd200, 10'd0, 10'd1023, 8'h00, $urandom_range(0, MaxGap));
    send_sample(32'd283, 10'd0, 10'd1023, 8'h00, $urandom_range(0, MaxGap));
    send_sample(32'd400, 10'd32, 10'd31, 8'h01, $urandom_range(0, MaxGap));
    settle();

    // zero timeouts, tonic 0 so that the minus-one button wraps to pitch 255
    write_config(7'd0, 16'd0, 16'd0);
    send_sample(32'd400, 10'd1023, 10'd1022, 8'h10, $urandom_range(0, MaxGap));
    send_sample(32'd401, 10'd1023, 10'd1022, 8'h10, $urandom_range(0, MaxGap));
    send_sample(32'd402, 10'd0, 10'd0, 8'h00, $urandom_range(0, MaxGap));
    send_sample(32'd403, 10'd1, 10'd0, 8'h80, $urandom_range(0, MaxGap));
    settle();

    // widest timeouts and top tonic, timestamps around the wrap
    write_config(7'd127, 16'hFFFF, 16'hFFFF);
    write_reg(RegUnused, $urandom());
    send_sample(32'hFFFF_FFF0, 10'd1023, 10'd0, 8'h6F, $urandom_range(0, MaxGap));
    send_sample(32'hFFFF_FFFF, 10'd1023, 10'd0, 8'h00, $urandom_range(0, MaxGap));
    send_sample(32'h0000_0000, 10'd0, 10'd0, 8'h00, $urandom_range(0, MaxGap));
    send_sample(32'h0000_FFFF, 10'd0, 10'd0, 8'h00, $urandom_range(0, MaxGap));
    send_sample(32'h0000_0000, 10'd1023, 10'd0, 8'hAA, $urandom_range(0, MaxGap));
    send_sample(32'h0001_0000, 10'd1023, 10'd0, 8'h55, $urandom_range(0, MaxGap));
    settle();

    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0: begin tn = 7'd60;  rt = 16'd40;    nl = 16'd200;   end
        1: begin tn = 7'd0;   rt = 16'd0;     nl = 16'd0;     end
        2: begin tn = 7'd127; rt = 16'hFFFF;  nl = 16'hFFFF;  end
        3: begin tn = 7'($urandom_range(0, 127)); rt = 16'd100; nl = 16'd300; end
        7: begin
          tn = 7'($urandom_range(0, 127));
          rt = 16'($urandom());
          nl = 16'($urandom());
        end
        default: begin
          tn = 7'($urandom_range(0, 127));
          rt = 16'($urandom_range(0, 400));
          nl = 16'($urandom_range(0, 800));
        end
      endcase
      write_config(tn, rt, nl);
      span = ((rt > nl) ? int'(rt) : int'(nl)) / 3 + 4;
      if (ph == 2 || ph == 7) now_ms = 32'hFFFF_FFFF - $urandom_range(0, 3 * span);
      no_idle <= (ph == 1 || ph == 6);
      for (int i = 0; i < PhaseItems; i++) begin
        // receiver holds off while the sender keeps offering back to back
        if (ph == 3 && i == 20) hold_asks <= hold_asks + 1;
        burst = (ph == 1 || ph == 6 || (ph == 3 && i >= 20 && i < 70));
        random_sample(span, burst);
      end
      settle();
    end

    $display("covered %0d samples over %0d register settings, %0d note on and %0d note off events",
             items_sent, settings_used, note_ons, note_offs);
    if (mismatches == 0 && outstanding == 0)
      $display("piezo_trigger_note_generator_tb OK");
    else
      $display("piezo_trigger_note_generator_tb NOT OK");
    $finish;
  end

endmodule
